[hw/rtl/positional_array_list_top_defines.svh]
// Assertion macros for the positional array list block.
// Used by positional_array_list_top; needs i_clk and i_rst_n in scope.
`ifndef POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional array list check failed");

// Antecedent implies consequent in the next cycle.
`define PAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional array list check failed");

`endif

[hw/rtl/pal_pkg.sv]
// Shared types and constants of the positional array list block.
// No dependencies; imported by pal_cell and positional_array_list_top.
`default_nettype none

package pal_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W      = 2;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 6;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 2'd0,
        K_DELETE = 2'd1,
        K_APPEND = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_BADPOS  = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_APPEND = 2'd3
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_EXEC = 2'd2
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/pal_cell.sv]
// One list slot: holds an entry, shifts with its neighbors, compares and selects.
// Depends on pal_pkg.
`default_nettype none

module pal_cell #(
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF,
    parameter int IW         = 5,
    parameter int FW         = 6,
    parameter int IDX        = 0
) (
    input  wire logic                  i_clk,
    input  wire pal_pkg::t_cell_op     i_op,
    input  wire logic [IW-1:0]         i_ptr,
    input  wire logic [FW-1:0]         i_fill,
    input  wire logic [DATA_WIDTH-1:0] i_key,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_entry,
    output logic                       o_match,
    output logic      [DATA_WIDTH-1:0] o_sel
);
    import pal_pkg::*;

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;
    logic                  at_ptr;
    logic                  past_ptr;

    assign at_ptr   = (IW'(IDX) == i_ptr);
    assign past_ptr = (IW'(IDX) > i_ptr);

    always_comb begin
        n_entry = r_entry;
        unique case (i_op)
            OP_HOLD: begin
                n_entry = r_entry;
            end
            OP_INSERT: begin
                // open a gap at the pointer, later entries move up
                if (past_ptr) begin
                    n_entry = i_left;
                end else if (at_ptr) begin
                    n_entry = i_key;
                end
            end
            OP_DELETE: begin
                if (past_ptr || at_ptr) begin
                    n_entry = i_right;
                end
            end
            OP_APPEND: begin
                if (at_ptr) begin
                    n_entry = i_key;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (FW'(IDX) < i_fill) && (r_entry == i_key);
    assign o_sel   = at_ptr ? r_entry : '0;

endmodule

`default_nettype wire

[hw/rtl/positional_array_list_top.sv]
// Top level of the positional array list: control, cell chain and output register.
// Depends on pal_pkg, pal_cell and positional_array_list_top_defines.svh.
`default_nettype none

// Ordered list of up to DEPTH entries held in a row of cells, one entry per cell.
// Each input item is one operation: insert at a 1-based position, delete at a
// position (the entry comes back in the result), or append a value only if no
// entry holds it. Every item yields one result with a status and the length
// after the operation. An item passes through accept, evaluate (every
// cell compares its entry with the value and the addressed cell presents its
// entry, OR-reduced across the chain into registers) and execute (all cells
// shift or load at once and the result register is written). A new item is
// taken once the block is back in idle, so one item is done before the next
// is accepted; a result that is not taken while the next one is ready holds
// the execute step. Entries carry no reset: only entries below the fill count
// are ever compared or returned.

module positional_array_list_top #(
    parameter int DEPTH      = pal_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  wire logic [pal_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  wire logic [pal_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [31:0] removed_value, [37:32] count, [39:38] zero
    output logic      [pal_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [2:0] status
    output logic      [pal_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import pal_pkg::*;

`include "positional_array_list_top_defines.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

    // control state
    t_state          r_state;
    t_state          n_state;
    logic [FW-1:0]   r_fill;
    logic [FW-1:0]   n_fill;
    logic            r_out_valid;

    // latched item
    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_value;

    // evaluate results
    logic                  r_hit;
    logic [DATA_WIDTH-1:0] r_rem;

    // output payload
    t_status           r_out_status;
    logic [VAL_W-1:0]  r_out_removed;
    logic [COUNT_W-1:0] r_out_count;

    // chain wiring
    logic [DATA_WIDTH-1:0] cell_entry [DEPTH];
    logic [DATA_WIDTH-1:0] cell_sel   [DEPTH];
    logic [DEPTH-1:0]      cell_match;
    logic [DATA_WIDTH-1:0] key;
    logic [IW-1:0]         ptr;
    t_cell_op              cell_op;
    logic [DATA_WIDTH-1:0] sel_or;

    logic              in_fire;
    logic              exec_fire;
    t_status           ex_status;
    logic [CW-1:0]     pos_w;
    logic [CW-1:0]     fill_w;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign key    = DATA_WIDTH'(r_value);
    assign pos_w  = CW'(r_pos);
    assign fill_w = CW'(r_fill);

    // append writes at the fill count, insert and delete at position minus one
    assign ptr = (t_kind'(r_kind) == K_APPEND) ? IW'(r_fill) : IW'(pos_w - CW'(1));

    // row of cells; cell 0 takes the key from the left, the last cell its own entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;
        if (g == 0) begin : g_first
            assign left_data = key;
        end else begin : g_mid
            assign left_data = cell_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_data = cell_entry[g];
        end else begin : g_inner
            assign right_data = cell_entry[g+1];
        end
        pal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .FW         (FW),
            .IDX        (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_ptr   (ptr),
            .i_fill  (r_fill),
            .i_key   (key),
            .i_left  (left_data),
            .i_right (right_data),
            .o_entry (cell_entry[g]),
            .o_match (cell_match[g]),
            .o_sel   (cell_sel[g])
        );
    end

    // only the addressed cell drives nonzero select data
    always_comb begin
        sel_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel_or = sel_or | cell_sel[k];
        end
    end

    // decide the outcome from the registered compare, the position and the fill count
    always_comb begin
        ex_status = ST_OK;
        unique case (t_kind'(r_kind))
            K_INSERT: begin
                if (fill_w >= CW'(DEPTH)) begin
                    ex_status = ST_FULL;
                end else if (pos_w == '0 || pos_w > fill_w + CW'(1)) begin
                    ex_status = ST_BADPOS;
                end
            end
            K_DELETE: begin
                if (r_fill == '0) begin
                    ex_status = ST_EMPTY;
                end else if (pos_w == '0 || pos_w > fill_w) begin
                    ex_status = ST_BADPOS;
                end
            end
            K_APPEND: begin
                if (r_hit) begin
                    ex_status = ST_PRESENT;
                end else if (fill_w >= CW'(DEPTH)) begin
                    ex_status = ST_FULL;
                end
            end
            default: begin
                // unknown operation code
                ex_status = ST_BADPOS;
            end
        endcase
    end

    // next state, cell command and fill update
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        cell_op = OP_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state = S_IDLE;
                    if (ex_status == ST_OK) begin
                        unique case (t_kind'(r_kind))
                            K_INSERT: begin
                                cell_op = OP_INSERT;
                                n_fill  = r_fill + FW'(1);
                            end
                            K_DELETE: begin
                                cell_op = OP_DELETE;
                                n_fill  = r_fill - FW'(1);
                            end
                            K_APPEND: begin
                                cell_op = OP_APPEND;
                                n_fill  = r_fill + FW'(1);
                            end
                            default: begin
                                cell_op = OP_HOLD;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: latch the item, the evaluate results and the result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind  <= s_axis_tuser;
            r_pos   <= s_axis_tdata[POS_W-1:0];
            r_value <= s_axis_tdata[POS_W+VAL_W-1:POS_W];
        end
        if (r_state == S_EVAL) begin
            r_hit <= |cell_match;
            r_rem <= sel_or;
        end
        if (exec_fire) begin
            r_out_status  <= ex_status;
            r_out_removed <= (ex_status == ST_OK && t_kind'(r_kind) == K_DELETE)
                             ? VAL_W'(r_rem) : '0;
            r_out_count   <= COUNT_W'(n_fill);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_count, r_out_removed});
    assign m_axis_tuser  = r_out_status;

    // fill never runs past the number of cells
    `PAL_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FW'(DEPTH))
    // a free output lets execute finish and return to idle
    `PAL_ASSERT_NEXT(a_exec_done, exec_fire, r_state == S_IDLE && r_out_valid)
    // only a successful delete hands back an entry
    `PAL_ASSERT_SAME(a_removed_zero, r_out_valid && r_out_status != ST_OK,
                     r_out_removed == '0)
    // a successful delete shortens the list by one
    `PAL_ASSERT_NEXT(a_delete_count,
                     exec_fire && ex_status == ST_OK && t_kind'(r_kind) == K_DELETE,
                     r_fill == $past(r_fill) - FW'(1))

endmodule

`default_nettype wire
